/* design/lpmdr_pkg.sv */
// lpmdr_pkg: shared types, constants and checksum helper for the dscp remarker
// no dependencies; imported by every module of the block
package lpmdr_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
  localparam logic [15:0] IPV4_MIN_FRAME = 16'd34;
  localparam logic [5:0]  MAX_PREFIX_LEN = 6'd32;

  // what an item does as it moves down the chain
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_DROP   = 2'd1,
    KIND_PASS   = 2'd2,
    KIND_LOOKUP = 2'd3
  } lpmdr_kind_t;

  // token carried from cell to cell
  typedef struct packed {
    lpmdr_kind_t kind;
    logic [5:0]  entry_index;
    logic [31:0] addr;         // entry prefix on writes, destination on lookups
    logic [5:0]  prefix_len;   // clamped to 32
    logic [5:0]  dscp;         // entry dscp on writes, best dscp on lookups
    logic        entry_valid;
    logic [7:0]  tos;
    logic [15:0] csum;
    logic        matched;
    logic [5:0]  best_len;
  } lpmdr_tok_t;

  function automatic logic [15:0] ones_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

/* design/lpmdr_cell.sv */
// lpmdr_cell: one prefix table slot plus one stage of the lookup chain
// depends on lpmdr_pkg
module lpmdr_cell import lpmdr_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_vld,
  input  lpmdr_tok_t in_tok,
  output logic       out_vld,
  output lpmdr_tok_t out_tok
);

  logic        slot_vld_r;
  logic [31:0] slot_prefix_r;
  logic [5:0]  slot_len_r;
  logic [5:0]  slot_dscp_r;
  logic        out_vld_r;
  lpmdr_tok_t  out_tok_r;
  lpmdr_tok_t  tok_nxt;
  logic [31:0] mask;
  logic        hit;
  logic        wr_here;

  always_comb begin
    if (slot_len_r == 6'd0) begin
      mask = 32'd0;
    end else begin
      mask = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - slot_len_r);
    end
  end

  assign hit     = slot_vld_r && (((slot_prefix_r ^ in_tok.addr) & mask) == 32'd0);
  assign wr_here = in_vld && (in_tok.kind == KIND_WRITE) &&
                   (int'(in_tok.entry_index) == CELL_INDEX);

  // longer prefix wins, equal length keeps the earlier slot
  always_comb begin
    tok_nxt = in_tok;
    if ((in_tok.kind == KIND_LOOKUP) && hit &&
        (!in_tok.matched || (slot_len_r > in_tok.best_len))) begin
      tok_nxt.matched  = 1'b1;
      tok_nxt.best_len = slot_len_r;
      tok_nxt.dscp     = slot_dscp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
      if (wr_here) begin
        slot_vld_r <= in_tok.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tok_r <= tok_nxt;
    if (wr_here) begin
      slot_prefix_r <= in_tok.addr;
      slot_len_r    <= in_tok.prefix_len;
      slot_dscp_r   <= in_tok.dscp;
    end
  end

  assign out_vld = out_vld_r;
  assign out_tok = out_tok_r;

endmodule

/* design/lpmdr_remark.sv */
// lpmdr_remark: end of chain, builds tos and incremental checksum, result register
// depends on lpmdr_pkg
module lpmdr_remark import lpmdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  lpmdr_tok_t  in_tok,
  input  logic        miss_clears_tos,
  output logic        out_valid,
  output logic        out_verdict,
  output logic        out_rewritten,
  output logic [7:0]  out_tos_out,
  output logic [15:0] out_checksum_out,
  output logic        out_matched
);

  logic        valid_r;
  logic        verdict_r, verdict_nxt;
  logic        rewritten_r, rewritten_nxt;
  logic [7:0]  tos_r, tos_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic        matched_r, matched_nxt;
  logic [7:0]  new_tos;
  logic [15:0] acc;

  assign new_tos = in_tok.matched ? {in_tok.dscp, 2'b00} : 8'd0;
  // rfc 1624: hc' = ~(~hc + ~m + m')
  assign acc = ones_add16(ones_add16(~in_tok.csum, ~{8'd0, in_tok.tos}), {8'd0, new_tos});

  always_comb begin
    verdict_nxt   = 1'b0;
    rewritten_nxt = 1'b0;
    tos_nxt       = in_tok.tos;
    csum_nxt      = in_tok.csum;
    matched_nxt   = 1'b0;
    case (in_tok.kind)
      KIND_WRITE: begin
        tos_nxt  = 8'd0;
        csum_nxt = 16'd0;
      end
      KIND_DROP: begin
        verdict_nxt = 1'b1;
      end
      KIND_PASS: begin
        verdict_nxt = 1'b0;
      end
      KIND_LOOKUP: begin
        matched_nxt = in_tok.matched;
        if (in_tok.matched || miss_clears_tos) begin
          rewritten_nxt = 1'b1;
          tos_nxt       = new_tos;
          csum_nxt      = ~acc;
        end
      end
      default: begin
        verdict_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r   <= verdict_nxt;
    rewritten_r <= rewritten_nxt;
    tos_r       <= tos_nxt;
    csum_r      <= csum_nxt;
    matched_r   <= matched_nxt;
  end

  assign out_valid        = valid_r;
  assign out_verdict      = verdict_r;
  assign out_rewritten    = rewritten_r;
  assign out_tos_out      = tos_r;
  assign out_checksum_out = csum_r;
  assign out_matched      = matched_r;

endmodule

/* design/lpm_dscp_remarker_unit.sv */
// path: each command passes through the register of every slot cell, then the result register, to the out_valid strobe
// throughput: one transfer per cycle, busy stays low; set by the slot chain, one slot per cycle
// reset (rst_n low, synchronous): all slots invalid, miss_clears_tos 0, chain emptied
// results appear for exactly one cycle on out_valid; the receiver cannot stall
// depends on lpmdr_pkg, lpmdr_cell, lpmdr_remark
module lpm_dscp_remarker_unit import lpmdr_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_prefix,
  input  logic [5:0]  in_entry_prefix_len,
  input  logic [5:0]  in_entry_dscp,
  input  logic        in_entry_valid,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_ether_type,
  input  logic [31:0] in_dest_addr,
  input  logic [7:0]  in_tos_in,
  input  logic [15:0] in_checksum_in,
  // result channel
  output logic        out_valid,
  output logic        out_verdict,
  output logic        out_rewritten,
  output logic [7:0]  out_tos_out,
  output logic [15:0] out_checksum_out,
  output logic        out_matched,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic        miss_clears_tos_r;
  logic        chain_vld [0:TABLE_ENTRIES];
  lpmdr_tok_t  chain_tok [0:TABLE_ENTRIES];
  lpmdr_kind_t kind;

  // the chain never holds off a transfer: each cell passes its token on every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_clears_tos_r <= 1'b0;
    end else if (cfg_wr_en) begin
      miss_clears_tos_r <= cfg_wr_data;
    end
  end

  // header checks are settled on entry, only full ipv4 headers search the table
  always_comb begin
    if (in_operation) begin
      kind = KIND_WRITE;
    end else if (in_frame_length < ETH_HDR_BYTES) begin
      kind = KIND_DROP;
    end else if (in_ether_type != ETHERTYPE_IPV4) begin
      kind = KIND_PASS;
    end else if (in_frame_length < IPV4_MIN_FRAME) begin
      kind = KIND_DROP;
    end else begin
      kind = KIND_LOOKUP;
    end
  end

  always_comb begin
    chain_vld[0]             = start && !busy;
    chain_tok[0].kind        = kind;
    chain_tok[0].entry_index = in_entry_index;
    chain_tok[0].addr        = in_operation ? in_entry_prefix : in_dest_addr;
    chain_tok[0].prefix_len  = (in_entry_prefix_len > MAX_PREFIX_LEN) ?
                               MAX_PREFIX_LEN : in_entry_prefix_len;
    chain_tok[0].dscp        = in_operation ? in_entry_dscp : 6'd0;
    chain_tok[0].entry_valid = in_entry_valid;
    chain_tok[0].tos         = in_tos_in;
    chain_tok[0].csum        = in_checksum_in;
    chain_tok[0].matched     = 1'b0;
    chain_tok[0].best_len    = 6'd0;
  end

  // one cell per slot; a write lands in its own slot as it passes, so items
  // behind it see the new entry and items ahead of it do not
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lpmdr_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .in_vld (chain_vld[i]),
      .in_tok (chain_tok[i]),
      .out_vld(chain_vld[i+1]),
      .out_tok(chain_tok[i+1])
    );
  end

  lpmdr_remark u_remark (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_vld          (chain_vld[TABLE_ENTRIES]),
    .in_tok          (chain_tok[TABLE_ENTRIES]),
    .miss_clears_tos (miss_clears_tos_r),
    .out_valid       (out_valid),
    .out_verdict     (out_verdict),
    .out_rewritten   (out_rewritten),
    .out_tos_out     (out_tos_out),
    .out_checksum_out(out_checksum_out),
    .out_matched     (out_matched)
  );

endmodule

/* tb/sv/lpmdr_tb_pkg.sv */
// lpmdr_tb_pkg: command codes and the command record shared by the remarker testbench
// no dependencies; imported by lpmdr_checker and tb_lpm_dscp_remarker_unit
package lpmdr_tb_pkg;

  typedef enum logic {
    OP_CLASSIFY = 1'b0,
    OP_WRITE    = 1'b1
  } lpmdr_op_t;

  // one command as driven on the in_ ports
  typedef struct packed {
    lpmdr_op_t   op;
    logic [5:0]  index;
    logic [31:0] prefix;
    logic [5:0]  plen;
    logic [5:0]  dscp;
    logic        valid;
    logic [15:0] flen;
    logic [15:0] etype;
    logic [31:0] dest;
    logic [7:0]  tos;
    logic [15:0] csum;
  } hdr_cmd_t;

endpackage

/* tb/sv/lpmdr_checker.sv */
// lpmdr_checker: watches the command, result and cfg ports of the dscp remarker,
// predicts every result and compares it; depends on lpmdr_pkg and lpmdr_tb_pkg
module lpmdr_checker import lpmdr_pkg::*, lpmdr_tb_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_entry_index,
  input  logic [31:0] in_entry_prefix,
  input  logic [5:0]  in_entry_prefix_len,
  input  logic [5:0]  in_entry_dscp,
  input  logic        in_entry_valid,
  input  logic [15:0] in_frame_length,
  input  logic [15:0] in_ether_type,
  input  logic [31:0] in_dest_addr,
  input  logic [7:0]  in_tos_in,
  input  logic [15:0] in_checksum_in,
  input  logic        out_valid,
  input  logic        out_verdict,
  input  logic        out_rewritten,
  input  logic [7:0]  out_tos_out,
  input  logic [15:0] out_checksum_out,
  input  logic        out_matched,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [5:0]  dscp;
    logic        valid;
  } route_slot_t;

  typedef struct packed {
    logic        verdict;
    logic        rewritten;
    logic [7:0]  tos;
    logic [15:0] csum;
    logic        matched;
  } remark_t;

  route_slot_t route_slots [TABLE_ENTRIES];
  logic        miss_clears;
  remark_t     pending_remarks [$];
  int unsigned errors = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // one's complement add with end-around carry
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic remark_t classify_header(input logic [15:0] flen,
                                              input logic [15:0] etype,
                                              input logic [31:0] dest,
                                              input logic [7:0]  tos,
                                              input logic [15:0] csum);
    remark_t     r;
    lpmdr_kind_t kind;
    logic [5:0]  best_len;
    logic [5:0]  best_dscp;
    logic [31:0] mask;
    logic [7:0]  new_tos;
    logic [15:0] acc;
    r = '{verdict: 1'b0, rewritten: 1'b0, tos: tos, csum: csum, matched: 1'b0};
    best_len = '0;
    best_dscp = '0;
    if (flen < ETH_HDR_BYTES) kind = KIND_DROP;
    else if (etype != ETHERTYPE_IPV4) kind = KIND_PASS;
    else if (flen < IPV4_MIN_FRAME) kind = KIND_DROP;
    else kind = KIND_LOOKUP;
    r.verdict = (kind == KIND_DROP);
    if (kind == KIND_LOOKUP) begin
      // longest prefix wins, strictly longer needed to displace an earlier slot
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!route_slots[i].valid) continue;
        mask = (route_slots[i].len == 0) ? 32'd0 : (~32'd0 << (32 - route_slots[i].len));
        if (((route_slots[i].prefix ^ dest) & mask) != 32'd0) continue;
        if (!r.matched || route_slots[i].len > best_len) begin
          r.matched = 1'b1;
          best_len  = route_slots[i].len;
          best_dscp = route_slots[i].dscp;
        end
      end
      if (r.matched || miss_clears) begin
        new_tos = r.matched ? {best_dscp, 2'b00} : 8'h00;
        acc = fold_add(~csum, ~{8'h00, tos});
        acc = fold_add(acc, {8'h00, new_tos});
        r.rewritten = 1'b1;
        r.tos       = new_tos;
        r.csum      = ~acc;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    remark_t got;
    remark_t want;
    if (!rst_n) begin
      foreach (route_slots[i]) route_slots[i] = '{prefix: '0, len: '0, dscp: '0, valid: 1'b0};
      miss_clears = 1'b0;
      pending_remarks.delete();
    end else begin
      if (out_valid) begin
        got = '{verdict: out_verdict, rewritten: out_rewritten, tos: out_tos_out,
                csum: out_checksum_out, matched: out_matched};
        if (pending_remarks.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          errors++;
        end else begin
          want = pending_remarks.pop_front();
          check_field("verdict", {15'd0, want.verdict}, {15'd0, got.verdict});
          check_field("rewritten", {15'd0, want.rewritten}, {15'd0, got.rewritten});
          check_field("tos_out", {8'd0, want.tos}, {8'd0, got.tos});
          check_field("checksum_out", want.csum, got.csum);
          check_field("matched", {15'd0, want.matched}, {15'd0, got.matched});
        end
      end
      if (cfg_wr_en) miss_clears = cfg_wr_data;
      if (start && !busy) begin
        if (in_operation == OP_WRITE) begin
          route_slots[in_entry_index] = '{
            prefix: in_entry_prefix,
            len:    (in_entry_prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : in_entry_prefix_len,
            dscp:   in_entry_dscp,
            valid:  in_entry_valid};
          pending_remarks.push_back('0);
        end else begin
          pending_remarks.push_back(classify_header(in_frame_length, in_ether_type,
                                                    in_dest_addr, in_tos_in, in_checksum_in));
        end
      end
    end
    outstanding <= pending_remarks.size();
    fail_count  <= errors;
  end

endmodule

/* tb/sv/tb_lpm_dscp_remarker_unit.sv */
// tb_lpm_dscp_remarker_unit: stimulus and verdict for the lpm dscp remarker
// depends on lpmdr_pkg, lpmdr_tb_pkg, lpmdr_checker and lpm_dscp_remarker_unit
module tb_lpm_dscp_remarker_unit import lpmdr_pkg::*, lpmdr_tb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_ENTRIES = 64;
  localparam int SEG_ITEMS     = 390;
  // ~1600 transfers plus six drains of the chain; the limit keeps a wide margin
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [5:0]  in_entry_index;
  logic [31:0] in_entry_prefix;
  logic [5:0]  in_entry_prefix_len;
  logic [5:0]  in_entry_dscp;
  logic        in_entry_valid;
  logic [15:0] in_frame_length;
  logic [15:0] in_ether_type;
  logic [31:0] in_dest_addr;
  logic [7:0]  in_tos_in;
  logic [15:0] in_checksum_in;
  logic        out_valid;
  logic        out_verdict;
  logic        out_rewritten;
  logic [7:0]  out_tos_out;
  logic [15:0] out_checksum_out;
  logic        out_matched;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;

  // prefixes last written per slot, only used to aim destinations at the table
  logic [31:0] known_prefix [TABLE_ENTRIES];

  lpm_dscp_remarker_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_entry_index, .in_entry_prefix, .in_entry_prefix_len,
    .in_entry_dscp, .in_entry_valid, .in_frame_length, .in_ether_type,
    .in_dest_addr, .in_tos_in, .in_checksum_in,
    .out_valid, .out_verdict, .out_rewritten, .out_tos_out, .out_checksum_out,
    .out_matched, .cfg_wr_en, .cfg_wr_data
  );

  lpmdr_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_entry_index, .in_entry_prefix, .in_entry_prefix_len,
    .in_entry_dscp, .in_entry_valid, .in_frame_length, .in_ether_type,
    .in_dest_addr, .in_tos_in, .in_checksum_in,
    .out_valid, .out_verdict, .out_rewritten, .out_tos_out, .out_checksum_out,
    .out_matched, .cfg_wr_en, .cfg_wr_data,
    .fail_count, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung block or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // table write command, header fields left at zero
  function automatic hdr_cmd_t route(input logic [5:0] idx, input logic [31:0] prefix,
                                     input logic [5:0] plen, input logic [5:0] dscp,
                                     input logic valid);
    hdr_cmd_t c;
    c = '0;
    c.op = OP_WRITE;
    c.index = idx;
    c.prefix = prefix;
    c.plen = plen;
    c.dscp = dscp;
    c.valid = valid;
    return c;
  endfunction

  // classify command for one header
  function automatic hdr_cmd_t frame(input logic [15:0] flen, input logic [15:0] etype,
                                     input logic [31:0] dest, input logic [7:0] tos,
                                     input logic [15:0] csum);
    hdr_cmd_t c;
    c = '0;
    c.op = OP_CLASSIFY;
    c.flen = flen;
    c.etype = etype;
    c.dest = dest;
    c.tos = tos;
    c.csum = csum;
    return c;
  endfunction

  // random command: mostly well-formed ipv4 headers aimed near stored prefixes,
  // a share of table writes, the rest malformed or non-ipv4 noise
  function automatic hdr_cmd_t random_cmd();
    hdr_cmd_t    c;
    int unsigned roll;
    c.op     = OP_CLASSIFY;
    c.index  = 6'($urandom_range(63));
    c.prefix = $urandom();
    c.dscp   = 6'($urandom_range(63));
    c.valid  = ($urandom_range(99) < 85);
    c.flen   = 16'($urandom());
    c.etype  = 16'($urandom());
    c.dest   = $urandom();
    c.tos    = 8'($urandom());
    c.csum   = 16'($urandom());
    // prefix length: mostly realistic, some default routes and oversize lengths
    case ($urandom_range(39))
      0:       c.plen = 6'd0;
      1, 2:    c.plen = 6'($urandom_range(7, 1));
      3, 4, 5: c.plen = 6'($urandom_range(63, 33));
      default: c.plen = 6'($urandom_range(32, 8));
    endcase
    roll = $urandom_range(99);
    if (roll < 20) begin
      c.op = OP_WRITE;
    end else if (roll < 88) begin
      c.flen  = 16'($urandom_range(1514, 34));
      c.etype = ETHERTYPE_IPV4;
      // flip a random number of trailing bits of a stored prefix
      if ($urandom_range(99) < 65)
        c.dest = known_prefix[$urandom_range(TABLE_ENTRIES - 1)] ^
                 ($urandom() >> $urandom_range(32));
    end else begin
      if ($urandom_range(1) == 0) c.flen = 16'($urandom_range(40));
      if ($urandom_range(1) == 0) c.etype = ETHERTYPE_IPV4;
    end
    return c;
  endfunction

  // one command transfer: random idle cycles first, then hold start until accepted
  task automatic send(input hdr_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start               <= 1'b1;
    in_operation        <= c.op;
    in_entry_index      <= c.index;
    in_entry_prefix     <= c.prefix;
    in_entry_prefix_len <= c.plen;
    in_entry_dscp       <= c.dscp;
    in_entry_valid      <= c.valid;
    in_frame_length     <= c.flen;
    in_ether_type       <= c.etype;
    in_dest_addr        <= c.dest;
    in_tos_in           <= c.tos;
    in_checksum_in      <= c.csum;
    if (c.op == OP_WRITE) known_prefix[c.index] = c.prefix;
    do @(posedge clk); while (busy);
  endtask

  // stop sending and wait until every predicted result has come back;
  // every command yields a result so the chain is empty afterwards
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_miss_policy(input logic clear);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= clear;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    foreach (known_prefix[i]) known_prefix[i] = '0;
    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_operation        <= OP_CLASSIFY;
    in_entry_index      <= '0;
    in_entry_prefix     <= '0;
    in_entry_prefix_len <= '0;
    in_entry_dscp       <= '0;
    in_entry_valid      <= 1'b0;
    in_frame_length     <= '0;
    in_ether_type       <= '0;
    in_dest_addr        <= '0;
    in_tos_in           <= '0;
    in_checksum_in      <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, miss policy at its reset value (keep tos)
    idle_pct = 26;
    // frame bound checks on an empty table
    send(frame(16'd0, ETHERTYPE_IPV4, 32'hC0A8_0101, 8'hFF, 16'hFFFF));   // empty frame
    send(frame(16'd13, ETHERTYPE_IPV4, 32'hC0A8_0101, 8'h2C, 16'h1111));  // one short of eth
    send(frame(16'd14, 16'h86DD, 32'hC0A8_0101, 8'hB8, 16'h2222));        // non-ipv4 passes
    send(frame(16'd33, ETHERTYPE_IPV4, 32'hC0A8_0101, 8'hB8, 16'h3333));  // truncated ip
    send(frame(16'd34, ETHERTYPE_IPV4, 32'hC0A8_0101, 8'hB8, 16'h1234));  // miss, no entries
    // build a small table: default route, /16, two tied /24s, host routes
    send(route(6'd0, 32'hFFFF_FFFF, 6'd0, 6'd5, 1'b1));   // len 0 ignores all prefix bits
    send(route(6'd63, 32'hC0A8_0000, 6'd16, 6'd46, 1'b1));
    send(route(6'd10, 32'hC0A8_0100, 6'd24, 6'd63, 1'b1));
    send(route(6'd6, 32'hC0A8_01AA, 6'd24, 6'd12, 1'b1)); // tie: lower slot must win
    send(route(6'd5, 32'hC0A8_01FF, 6'd40, 6'd1, 1'b1));  // oversize length acts as /32
    send(route(6'd62, 32'h0A00_0000, 6'd63, 6'd0, 1'b1)); // largest length field, dscp 0
    send(frame(16'd34, ETHERTYPE_IPV4, 32'hC0A8_01FF, 8'h03, 16'h0000));  // host route
    send(frame(16'd60, ETHERTYPE_IPV4, 32'hC0A8_0107, 8'h00, 16'hB1E6));  // tied /24
    send(frame(16'd1500, ETHERTYPE_IPV4, 32'hC0A8_FFFF, 8'hFF, 16'h0001)); // /16 only
    send(frame(16'hFFFF, ETHERTYPE_IPV4, 32'h0102_0304, 8'h00, 16'hFFFF)); // default route
    // tos already equals the new value: checksum still goes through the update
    send(frame(16'd100, ETHERTYPE_IPV4, 32'h0808_0808, 8'h14, 16'hFFFF));
    send(frame(16'd64, ETHERTYPE_IPV4, 32'h0A00_0000, 8'hFF, 16'hFFFF));  // dscp 0 match
    send(route(6'd0, 32'h0000_0000, 6'd0, 6'd5, 1'b0));   // remove the default route
    send(frame(16'd64, ETHERTYPE_IPV4, 32'h0102_0304, 8'hAB, 16'h5555));  // miss keeps tos
    send(frame(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));      // all ones, non-ip
    // switch misses to clearing tos
    drain();
    set_miss_policy(1'b1);
    send(frame(16'd34, ETHERTYPE_IPV4, 32'h0102_0304, 8'hAB, 16'h5555));  // miss clears tos
    send(frame(16'd34, ETHERTYPE_IPV4, 32'h0102_0304, 8'h00, 16'hFFFF));  // already zero
    send(frame(16'd20, ETHERTYPE_IPV4, 32'h0102_0304, 8'hAB, 16'h5555));  // short still drops

    // random part in four segments; each starts from an idle block with a new
    // miss policy, sender idling light, then heavier, then not at all
    for (int seg = 0; seg < 4; seg++) begin
      drain();
      set_miss_policy(seg[0]);
      case (seg)
        0:       idle_pct = 26;
        1:       idle_pct = 45;
        default: idle_pct = 0;
      endcase
      repeat (SEG_ITEMS) send(random_cmd());
    end

    // let the last results come back, then a margin for anything stray
    drain();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/lpmdr_pkg.sv
design/lpmdr_cell.sv
design/lpmdr_remark.sv
design/lpm_dscp_remarker_unit.sv
tb/sv/lpmdr_tb_pkg.sv
tb/sv/lpmdr_checker.sv
tb/sv/tb_lpm_dscp_remarker_unit.sv
